// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared widths, flag and status codes, controller states and tree helpers.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TREE_LEVELS     = 10;
  localparam int MIN_BLOCK_BYTES = 128;

  localparam int ADDR_W     = 48;
  localparam int REQ_W      = 24;
  localparam int STAT_W     = 2;
  localparam int FLAG_W     = 3;
  localparam int MIN_SHIFT  = $clog2(MIN_BLOCK_BYTES);
  localparam int HEAP_SHIFT = MIN_SHIFT + TREE_LEVELS - 1;
  localparam int OFF_W      = HEAP_SHIFT;
  localparam int NODE_COUNT = (2 ** TREE_LEVELS) - 1;
  localparam int NODE_W     = TREE_LEVELS;
  localparam int IDX_W      = TREE_LEVELS - 1;
  localparam int LVL_W      = (TREE_LEVELS > 2) ? $clog2(TREE_LEVELS) : 1;
  localparam int SH_W       = $clog2(HEAP_SHIFT + 1);
  localparam int CMP_W      = (REQ_W > HEAP_SHIFT + 1) ? REQ_W : HEAP_SHIFT + 1;

  localparam logic [CMP_W-1:0] HEAP_BYTES =
    CMP_W'(MIN_BLOCK_BYTES) << (TREE_LEVELS - 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

  localparam logic [FLAG_W-1:0] FLAG_NONE        = 3'b000;
  localparam logic [FLAG_W-1:0] FLAG_VALID       = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_SPLIT       = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_ALLOC       = 3'b100;
  localparam logic [FLAG_W-1:0] FLAG_SPLIT_VALID = 3'b011;
  localparam logic [FLAG_W-1:0] FLAG_ALLOC_VALID = 3'b101;

  localparam logic [NODE_W-1:0] CLEAR_LAST = NODE_W'(NODE_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SPLIT_A,
    S_SPLIT_B,
    S_MARK,
    S_FREE_RD,
    S_FREE_CK,
    S_MG_WR,
    S_MG_CK,
    S_MG_CLR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [FLAG_W-1:0] wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [NODE_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [IDX_W-1:0] idx);
    logic [NODE_W-1:0] one;
    one = NODE_W'(1);
    return ((one << lvl) - one) + NODE_W'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] level_last(input logic [LVL_W-1:0] lvl);
    logic [NODE_W-1:0] one;
    one = NODE_W'(1);
    return IDX_W'((one << lvl) - one);
  endfunction

  function automatic logic [SH_W-1:0] block_shift(input logic [LVL_W-1:0] lvl);
    return SH_W'(HEAP_SHIFT) - SH_W'(lvl);
  endfunction

  function automatic logic req_fits(input logic [REQ_W-1:0] req);
    return CMP_W'(req) <= HEAP_BYTES;
  endfunction

  function automatic logic [LVL_W-1:0] want_level(input logic [REQ_W-1:0] req);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int k = TREE_LEVELS - 1; k >= 0; k--) begin
      if (CMP_W'(req) <= (CMP_W'(MIN_BLOCK_BYTES) << k)) begin
        lvl = LVL_W'(TREE_LEVELS - 1 - k);
      end
    end
    return lvl;
  endfunction

endpackage

// ===== design/bba_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Carries one allocate or free item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [bba_pkg::REQ_W-1:0]    request_bytes;
  logic [bba_pkg::ADDR_W-1:0]   free_address;

  modport source (output valid, operation, request_bytes, free_address, input ready);
  modport sink   (input valid, operation, request_bytes, free_address, output ready);
endinterface

// ===== design/bba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Carries one result item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bba_pkg::ADDR_W-1:0]   block_address;
  logic [bba_pkg::STAT_W-1:0]   status;

  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

// ===== design/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a heap from a binary tree of
// node flags held in a single-port-write, single-port-read memory.
// An allocate is paced by a scan of one node per cycle through the flag memory,
// from the wanted level up to the root; a free walks the tree one level at a time.
// One item is in work at a time; the result register lets the next item in.
// After reset a clearing pass writes every node, the root as valid, before the
// first item is accepted.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::ADDR_W-1:0]  cfg_wdata_i,
  bba_req_if.sink                     req_i,
  bba_rsp_if.source                   rsp_o
);

  logic [bba_pkg::ADDR_W-1:0] heap_base_q;
  logic                       out_vld_q;
  logic [bba_pkg::ADDR_W-1:0] out_addr_q;
  logic [bba_pkg::STAT_W-1:0] out_stat_q;

  logic                       res_valid;
  logic                       res_ready;
  logic [bba_pkg::ADDR_W-1:0] res_addr;
  logic [bba_pkg::STAT_W-1:0] res_status;
  bba_pkg::mem_req_t          mem_req;
  logic [bba_pkg::FLAG_W-1:0] mem_rdata;

  assign res_ready = !out_vld_q || rsp_o.ready;

  bba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_ready_o   (req_i.ready),
    .op_i         (req_i.operation),
    .req_bytes_i  (req_i.request_bytes),
    .free_addr_i  (req_i.free_address),
    .heap_base_i  (heap_base_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_addr_o   (res_addr),
    .res_status_o (res_status),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  bba_node_ram u_ram (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        heap_base_q <= cfg_wdata_i;
      end
      if (res_valid && res_ready) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_addr_q <= res_addr;
      out_stat_q <= res_status;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status        = out_stat_q;

endmodule

// ===== design/bba_node_ram.sv =====
// ----------------------------------------------------------------------------
// Node flag memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_node_ram (
  input  logic                        clk_i,
  input  bba_pkg::mem_req_t           mem_req_i,
  output logic [bba_pkg::FLAG_W-1:0]  rdata_o
);

  logic [bba_pkg::FLAG_W-1:0] mem_q [bba_pkg::NODE_COUNT];
  logic [bba_pkg::FLAG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the node flag memory, at most one read and one write per cycle, to allocate and free blocks.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [bba_pkg::REQ_W-1:0]   req_bytes_i,
  input  logic [bba_pkg::ADDR_W-1:0]  free_addr_i,
  input  logic [bba_pkg::ADDR_W-1:0]  heap_base_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [bba_pkg::ADDR_W-1:0]  res_addr_o,
  output logic [bba_pkg::STAT_W-1:0]  res_status_o,
  output bba_pkg::mem_req_t           mem_req_o,
  input  logic [bba_pkg::FLAG_W-1:0]  mem_rdata_i
);

  bba_pkg::state_e state_q, state_d;

  logic [bba_pkg::NODE_W-1:0] clr_q, clr_d;
  logic                       op_q, op_d;
  logic [bba_pkg::REQ_W-1:0]  reqb_q, reqb_d;
  logic [bba_pkg::ADDR_W-1:0] faddr_q, faddr_d;
  logic [bba_pkg::LVL_W-1:0]  want_q, want_d;
  logic [bba_pkg::LVL_W-1:0]  lvl_q, lvl_d;
  logic [bba_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                       iss_done_q, iss_done_d;
  logic                       p_vld_q, p_vld_d;
  logic [bba_pkg::LVL_W-1:0]  p_lvl_q, p_lvl_d;
  logic [bba_pkg::IDX_W-1:0]  p_idx_q, p_idx_d;
  logic [bba_pkg::OFF_W-1:0]  off_q, off_d;
  logic [bba_pkg::ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [bba_pkg::STAT_W-1:0] res_stat_q, res_stat_d;

  logic                       accept;
  logic                       fits;
  logic [bba_pkg::ADDR_W-1:0] free_diff;
  logic                       free_oob;
  logic                       scan_hit;
  logic                       scan_empty;
  logic                       scan_last;
  logic [bba_pkg::SH_W-1:0]   free_sh;
  logic [bba_pkg::OFF_W-1:0]  free_mask;
  logic                       misaligned;
  logic [bba_pkg::IDX_W-1:0]  free_idx;
  logic [bba_pkg::LVL_W-1:0]  lvl_inc;
  logic                       node_valid;
  logic                       node_alloc;
  logic                       buddy_busy;

  assign accept     = in_valid_i && (state_q == bba_pkg::S_IDLE);
  assign fits       = bba_pkg::req_fits(reqb_q);
  assign free_diff  = faddr_q - heap_base_i;
  assign free_oob   = |free_diff[bba_pkg::ADDR_W-1:bba_pkg::OFF_W];
  assign scan_hit   = p_vld_q && (mem_rdata_i == bba_pkg::FLAG_VALID);
  assign scan_empty = iss_done_q && !p_vld_q;
  assign scan_last  = (idx_q == bba_pkg::level_last(lvl_q));
  assign free_sh    = bba_pkg::block_shift(lvl_q);
  assign free_mask  = (bba_pkg::OFF_W'(1) << free_sh) - bba_pkg::OFF_W'(1);
  assign misaligned = |(off_q & free_mask);
  assign free_idx   = bba_pkg::IDX_W'(off_q >> free_sh);
  assign lvl_inc    = lvl_q + bba_pkg::LVL_W'(1);
  assign node_valid = |(mem_rdata_i & bba_pkg::FLAG_VALID);
  assign node_alloc = |(mem_rdata_i & bba_pkg::FLAG_ALLOC);
  assign buddy_busy = |(mem_rdata_i & (bba_pkg::FLAG_SPLIT | bba_pkg::FLAG_ALLOC));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        if (clr_q == bba_pkg::CLEAR_LAST) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (accept) state_d = bba_pkg::S_DECODE;
      end
      bba_pkg::S_DECODE: begin
        if (op_q == bba_pkg::OP_ALLOC) begin
          state_d = fits ? bba_pkg::S_SCAN : bba_pkg::S_RESP;
        end else begin
          state_d = free_oob ? bba_pkg::S_RESP : bba_pkg::S_FREE_RD;
        end
      end
      bba_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_d = (p_lvl_q < want_q) ? bba_pkg::S_SPLIT_A : bba_pkg::S_MARK;
        end else if (scan_empty) begin
          state_d = bba_pkg::S_RESP;
        end
      end
      bba_pkg::S_SPLIT_A: state_d = bba_pkg::S_SPLIT_B;
      bba_pkg::S_SPLIT_B: begin
        state_d = (lvl_inc < want_q) ? bba_pkg::S_SPLIT_A : bba_pkg::S_MARK;
      end
      bba_pkg::S_MARK: state_d = bba_pkg::S_RESP;
      bba_pkg::S_FREE_RD: begin
        state_d = misaligned ? bba_pkg::S_RESP : bba_pkg::S_FREE_CK;
      end
      bba_pkg::S_FREE_CK: begin
        if (node_valid) begin
          state_d = node_alloc ? bba_pkg::S_MG_WR : bba_pkg::S_RESP;
        end else begin
          state_d = (lvl_q == '0) ? bba_pkg::S_RESP : bba_pkg::S_FREE_RD;
        end
      end
      bba_pkg::S_MG_WR: begin
        state_d = (lvl_q == '0) ? bba_pkg::S_RESP : bba_pkg::S_MG_CK;
      end
      bba_pkg::S_MG_CK: begin
        state_d = buddy_busy ? bba_pkg::S_RESP : bba_pkg::S_MG_CLR;
      end
      bba_pkg::S_MG_CLR: state_d = bba_pkg::S_MG_WR;
      bba_pkg::S_RESP: begin
        if (res_ready_i) state_d = bba_pkg::S_IDLE;
      end
      default: state_d = bba_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    clr_d      = clr_q;
    op_d       = op_q;
    reqb_d     = reqb_q;
    faddr_d    = faddr_q;
    want_d     = want_q;
    lvl_d      = lvl_q;
    idx_d      = idx_q;
    iss_done_d = iss_done_q;
    p_vld_d    = p_vld_q;
    p_lvl_d    = p_lvl_q;
    p_idx_d    = p_idx_q;
    off_d      = off_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    mem_req_o  = '0;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        mem_req_o.wdata = (clr_q == '0) ? bba_pkg::FLAG_VALID : bba_pkg::FLAG_NONE;
        clr_d           = clr_q + bba_pkg::NODE_W'(1);
      end
      bba_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = op_i;
          reqb_d  = req_bytes_i;
          faddr_d = free_addr_i;
        end
      end
      bba_pkg::S_DECODE: begin
        res_addr_d = '0;
        if (op_q == bba_pkg::OP_ALLOC) begin
          res_stat_d = bba_pkg::STAT_NO_SPACE;
          want_d     = bba_pkg::want_level(reqb_q);
          lvl_d      = bba_pkg::want_level(reqb_q);
          idx_d      = '0;
          iss_done_d = 1'b0;
          p_vld_d    = 1'b0;
        end else begin
          res_stat_d = bba_pkg::STAT_BAD_FREE;
          off_d      = free_diff[bba_pkg::OFF_W-1:0];
          lvl_d      = bba_pkg::LVL_W'(bba_pkg::TREE_LEVELS - 1);
        end
      end
      bba_pkg::S_SCAN: begin
        if (scan_hit) begin
          lvl_d   = p_lvl_q;
          idx_d   = p_idx_q;
          p_vld_d = 1'b0;
        end else begin
          mem_req_o.re    = !iss_done_q;
          mem_req_o.raddr = bba_pkg::node_addr(lvl_q, idx_q);
          p_vld_d         = !iss_done_q;
          p_lvl_d         = lvl_q;
          p_idx_d         = idx_q;
          if (!iss_done_q) begin
            if (scan_last) begin
              if (lvl_q == '0) begin
                iss_done_d = 1'b1;
              end else begin
                lvl_d = lvl_q - bba_pkg::LVL_W'(1);
                idx_d = '0;
              end
            end else begin
              idx_d = idx_q + bba_pkg::IDX_W'(1);
            end
          end
        end
      end
      bba_pkg::S_SPLIT_A: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = bba_pkg::node_addr(lvl_q, idx_q);
        mem_req_o.wdata = bba_pkg::FLAG_SPLIT_VALID;
      end
      bba_pkg::S_SPLIT_B: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = bba_pkg::node_addr(lvl_inc, (idx_q << 1) | bba_pkg::IDX_W'(1));
        mem_req_o.wdata = bba_pkg::FLAG_VALID;
        lvl_d           = lvl_inc;
        idx_d           = idx_q << 1;
      end
      bba_pkg::S_MARK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = bba_pkg::node_addr(lvl_q, idx_q);
        mem_req_o.wdata = bba_pkg::FLAG_ALLOC_VALID;
        res_addr_d      = heap_base_i +
                          (bba_pkg::ADDR_W'(idx_q) << bba_pkg::block_shift(lvl_q));
        res_stat_d      = bba_pkg::STAT_OK;
      end
      bba_pkg::S_FREE_RD: begin
        mem_req_o.re    = !misaligned;
        mem_req_o.raddr = bba_pkg::node_addr(lvl_q, free_idx);
        idx_d           = free_idx;
      end
      bba_pkg::S_FREE_CK: begin
        if (!node_valid && (lvl_q != '0)) begin
          lvl_d = lvl_q - bba_pkg::LVL_W'(1);
        end
      end
      bba_pkg::S_MG_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = bba_pkg::node_addr(lvl_q, idx_q);
        mem_req_o.wdata = bba_pkg::FLAG_VALID;
        mem_req_o.re    = (lvl_q != '0);
        mem_req_o.raddr = bba_pkg::node_addr(lvl_q, idx_q ^ bba_pkg::IDX_W'(1));
        res_stat_d      = bba_pkg::STAT_OK;
      end
      bba_pkg::S_MG_CK: begin
        mem_req_o.we    = !buddy_busy;
        mem_req_o.waddr = bba_pkg::node_addr(lvl_q, idx_q ^ bba_pkg::IDX_W'(1));
        mem_req_o.wdata = bba_pkg::FLAG_NONE;
      end
      bba_pkg::S_MG_CLR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = bba_pkg::node_addr(lvl_q, idx_q);
        mem_req_o.wdata = bba_pkg::FLAG_NONE;
        lvl_d           = lvl_q - bba_pkg::LVL_W'(1);
        idx_d           = idx_q >> 1;
      end
      bba_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bba_pkg::S_CLEAR;
      clr_q      <= '0;
      iss_done_q <= 1'b0;
      p_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      iss_done_q <= iss_done_d;
      p_vld_q    <= p_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    reqb_q     <= reqb_d;
    faddr_q    <= faddr_d;
    want_q     <= want_d;
    lvl_q      <= lvl_d;
    idx_q      <= idx_d;
    p_lvl_q    <= p_lvl_d;
    p_idx_q    <= p_idx_d;
    off_q      <= off_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  assign in_ready_o   = (state_q == bba_pkg::S_IDLE);
  assign res_valid_o  = (state_q == bba_pkg::S_RESP);
  assign res_addr_o   = res_addr_q;
  assign res_status_o = res_stat_q;

endmodule
